/* hw/rtl/srau_pkg.sv */
// srau_pkg: shared types and constants of the security region attribution unit
// used by srau_ctrl, srau_datapath and security_region_attribution_unit
`default_nettype none

package srau_pkg;

  localparam int ADDR_W  = 32;
  localparam int BLK_W   = 27;
  localparam int RIDX_W  = 3;
  localparam int CNT_W   = 4;
  localparam int WLEN_W  = 13;

  // attribution codes
  localparam logic [1:0] ATTR_SECURE    = 2'd0;
  localparam logic [1:0] ATTR_CALLABLE  = 2'd1;
  localparam logic [1:0] ATTR_NONSECURE = 2'd2;

  // test-target response bit positions
  localparam int TT_VALID_BIT = 17;
  localparam int TT_R_BIT     = 18;
  localparam int TT_RW_BIT    = 19;
  localparam int TT_NSR_BIT   = 20;
  localparam int TT_NSRW_BIT  = 21;
  localparam int TT_S_BIT     = 22;
  localparam int TT_REG_LSB   = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_UNIT_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_ALL_NONSECURE    = 2'd1;
  localparam logic [1:0] CFG_REGIONS_PRESENT  = 2'd2;
  localparam logic [1:0] CFG_EXTENSION_ENABLE = 2'd3;

  // item operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct packed {
    logic load;   // capture a lookup transaction
    logic write;  // load one region entry
    logic step;   // examine one region
    logic emit;   // fill the result register
  } srau_cmd_t;

  typedef struct packed {
    logic scan_none;  // no region to examine
    logic scan_last;  // current region is the last one searched
    logic out_busy;   // result register holds an untaken result
  } srau_status_t;

endpackage

`default_nettype wire

/* hw/rtl/srau_ctrl.sv */
// srau_ctrl: sequencing state machine of the attribution unit
// depends on srau_pkg for the command and status structs
`default_nettype none

module srau_ctrl
  import srau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  input  wire logic         operation,
  output logic              item_stall,
  input  wire srau_status_t sts,
  output srau_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (operation == OP_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = sts.scan_none ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/srau_datapath.sv */
// srau_datapath: region table, configuration registers, region scan and result register
// depends on srau_pkg; driven by srau_ctrl commands
`default_nettype none

module srau_datapath
  import srau_pkg::*;
#(
  parameter int REGION_COUNT = 8,
  parameter int PAGE_BYTES   = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srau_cmd_t          cmd,
  output srau_status_t            sts,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data,
  input  wire logic [ADDR_W-1:0]  address,
  input  wire logic               secure_state,
  input  wire logic               idau_nonsecure,
  input  wire logic               idau_callable,
  input  wire logic               idau_exempt,
  input  wire logic [RIDX_W-1:0]  region_index,
  input  wire logic [BLK_W-1:0]   region_base,
  input  wire logic [BLK_W-1:0]   region_limit,
  input  wire logic               region_enable,
  input  wire logic               region_callable,
  input  wire logic               result_stall,
  output logic                    result_valid,
  output logic [1:0]              attribution,
  output logic                    access_permitted,
  output logic [RIDX_W-1:0]       matched_region,
  output logic                    matched_valid,
  output logic [ADDR_W-1:0]       test_target_word,
  output logic [ADDR_W-1:0]       window_base,
  output logic [WLEN_W-1:0]       window_length
);

  localparam int IDX_W     = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int PAGE_BITS = $clog2(PAGE_BYTES);

  // configuration
  logic             unit_enable;
  logic             all_nonsecure;
  logic [CNT_W-1:0] regions_present;
  logic             extension_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_enable      <= 1'b0;
      all_nonsecure    <= 1'b0;
      regions_present  <= CNT_W'(8);
      extension_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNIT_ENABLE:      unit_enable      <= cfg_data[0];
        CFG_ALL_NONSECURE:    all_nonsecure    <= cfg_data[0];
        CFG_REGIONS_PRESENT:  regions_present  <= cfg_data;
        CFG_EXTENSION_ENABLE: extension_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // region table
  logic [BLK_W-1:0] base_table     [REGION_COUNT];
  logic [BLK_W-1:0] limit_table    [REGION_COUNT];
  logic             enable_marks   [REGION_COUNT];
  logic             callable_marks [REGION_COUNT];

  for (genvar g = 0; g < REGION_COUNT; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (rst) begin
        base_table[g]     <= '0;
        limit_table[g]    <= '0;
        enable_marks[g]   <= 1'b0;
        callable_marks[g] <= 1'b0;
      end else if (cmd.write && (region_index == RIDX_W'(g))) begin
        base_table[g]     <= region_base;
        limit_table[g]    <= region_limit;
        enable_marks[g]   <= region_enable;
        callable_marks[g] <= region_callable;
      end
    end
  end

  // searched count and scan status
  logic [CNT_W-1:0] n_search;
  logic [IDX_W-1:0] scan_idx;

  assign n_search = (regions_present > CNT_W'(REGION_COUNT)) ? CNT_W'(REGION_COUNT)
                                                              : regions_present;
  assign sts.scan_none = !unit_enable || (n_search == '0);
  assign sts.scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == n_search);
  assign sts.out_busy  = result_valid && result_stall;

  // captured lookup
  logic [ADDR_W-1:0] lk_addr;
  logic              lk_sec, lk_ins, lk_insc, lk_iex;
  logic [1:0]        hits;
  logic [RIDX_W-1:0] first_idx;
  logic              first_call;
  logic [ADDR_W-1:0] win_lo;
  logic [ADDR_W:0]   win_hi;

  // one region examined per step
  logic [ADDR_W-1:0] r_lo, r_hi;
  logic [ADDR_W:0]   r_end;
  logic              r_en, r_match;
  logic [ADDR_W-1:0] lo_next, lo_mid;
  logic [ADDR_W:0]   hi_next, hi_mid;

  assign r_en    = enable_marks[scan_idx];
  assign r_lo    = {base_table[scan_idx], 5'd0};
  assign r_hi    = {limit_table[scan_idx], 5'h1f};
  assign r_end   = {1'b0, r_hi} + (ADDR_W+1)'(1);
  assign r_match = r_en && (lk_addr >= r_lo) && (lk_addr <= r_hi);

  always_comb begin
    lo_mid = win_lo;
    hi_mid = win_hi;
    if (r_lo > lk_addr) begin
      if ({1'b0, r_lo} < hi_mid) hi_mid = {1'b0, r_lo};
    end else if (r_lo > lo_mid) begin
      lo_mid = r_lo;
    end
    lo_next = lo_mid;
    hi_next = hi_mid;
    if (r_end > {1'b0, lk_addr}) begin
      if (r_end < hi_next) hi_next = r_end;
    end else if (r_end[ADDR_W-1:0] > lo_next) begin
      lo_next = r_end[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lk_addr    <= address;
      lk_sec     <= secure_state;
      lk_ins     <= idau_nonsecure;
      lk_insc    <= idau_callable;
      lk_iex     <= idau_exempt;
      hits       <= '0;
      first_idx  <= '0;
      first_call <= 1'b0;
      scan_idx   <= '0;
      win_lo     <= {address[ADDR_W-1:PAGE_BITS], PAGE_BITS'(0)};
      win_hi     <= {1'b0, address[ADDR_W-1:PAGE_BITS], PAGE_BITS'(0)}
                    + (ADDR_W+1)'(PAGE_BYTES);
    end else if (cmd.step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (r_match) begin
        if (hits == 2'd0) begin
          first_idx  <= RIDX_W'(scan_idx);
          first_call <= callable_marks[scan_idx];
        end
        if (hits != 2'd2) hits <= hits + 2'd1;
      end
      if (r_en) begin
        win_lo <= lo_next;
        win_hi <= hi_next;
      end
    end
  end

  // attribution from the scan summary
  logic              f_valid, f_ns, f_nsc, f_ns1, f_nsc1;
  logic [1:0]        f_attr;
  logic [ADDR_W-1:0] f_word;

  always_comb begin
    f_valid = unit_enable && (hits == 2'd1);
    f_ns    = unit_enable ? (f_valid && !first_call) : all_nonsecure;
    f_nsc   = f_valid && first_call;
    f_ns1   = f_ns && lk_ins;
    f_nsc1  = f_nsc && (lk_ins || lk_insc);
    priority if (!extension_enable) begin
      f_attr = ATTR_NONSECURE;
    end else if (lk_iex) begin
      f_attr = ATTR_SECURE;
    end else if (f_ns1) begin
      f_attr = ATTR_NONSECURE;
    end else if (f_nsc1) begin
      f_attr = ATTR_CALLABLE;
    end else begin
      f_attr = ATTR_SECURE;
    end
    f_word = '0;
    if (lk_sec) begin
      f_word[TT_S_BIT] = (f_attr != ATTR_NONSECURE);
      if (f_valid) begin
        f_word[TT_REG_LSB +: RIDX_W] = first_idx;
        f_word[TT_VALID_BIT]         = 1'b1;
      end
      f_word[TT_NSR_BIT]  = (f_attr == ATTR_NONSECURE);
      f_word[TT_NSRW_BIT] = (f_attr == ATTR_NONSECURE);
    end
    f_word[TT_R_BIT]  = 1'b1;
    f_word[TT_RW_BIT] = 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  logic [ADDR_W:0] win_len_full;
  assign win_len_full = win_hi - {1'b0, win_lo};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      attribution      <= f_attr;
      access_permitted <= !extension_enable || lk_sec || (f_attr == ATTR_NONSECURE);
      matched_region   <= f_valid ? first_idx : '0;
      matched_valid    <= f_valid;
      test_target_word <= f_word;
      window_base      <= win_lo;
      window_length    <= win_len_full[WLEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/security_region_attribution_unit.sv */
// lookup: accept, then one step per searched region, then a finishing step; result registered
// the finishing step waits while the result register holds an untaken result
// no new item is taken until a lookup finishes; one shared comparator examines each region
// a region write transaction is taken in idle and gives no result
// synchronous active-high reset clears the region table to disabled and loads config defaults
`default_nettype none

module security_region_attribution_unit
  import srau_pkg::*;
#(
  parameter int REGION_COUNT = 8,
  parameter int PAGE_BYTES   = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data,
  // item channel
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               operation,
  input  wire logic [ADDR_W-1:0]  address,
  input  wire logic               secure_state,
  input  wire logic               idau_nonsecure,
  input  wire logic               idau_callable,
  input  wire logic               idau_exempt,
  input  wire logic [RIDX_W-1:0]  region_index,
  input  wire logic [BLK_W-1:0]   region_base,
  input  wire logic [BLK_W-1:0]   region_limit,
  input  wire logic               region_enable,
  input  wire logic               region_callable,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [1:0]              attribution,
  output logic                    access_permitted,
  output logic [RIDX_W-1:0]       matched_region,
  output logic                    matched_valid,
  output logic [ADDR_W-1:0]       test_target_word,
  output logic [ADDR_W-1:0]       window_base,
  output logic [WLEN_W-1:0]       window_length
);

  srau_cmd_t    cmd;
  srau_status_t sts;

  // config registers take a transaction in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: idle / scan regions / deliver
  srau_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (operation),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // region table, scan unit and result register
  srau_datapath #(
    .REGION_COUNT (REGION_COUNT),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .address          (address),
    .secure_state     (secure_state),
    .idau_nonsecure   (idau_nonsecure),
    .idau_callable    (idau_callable),
    .idau_exempt      (idau_exempt),
    .region_index     (region_index),
    .region_base      (region_base),
    .region_limit     (region_limit),
    .region_enable    (region_enable),
    .region_callable  (region_callable),
    .result_stall     (result_stall),
    .result_valid     (result_valid),
    .attribution      (attribution),
    .access_permitted (access_permitted),
    .matched_region   (matched_region),
    .matched_valid    (matched_valid),
    .test_target_word (test_target_word),
    .window_base      (window_base),
    .window_length    (window_length)
  );

  // a region write transaction never raises a result
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (operation == OP_WRITE)) |=> !$rose(result_valid))
    else $error("result raised by a region write");

  // a lookup transaction occupies the block in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (operation == OP_LOOKUP)) |=> item_stall)
    else $error("new transaction taken while a lookup is in progress");

  // secure flag in the response word never goes with non-secure attribution
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && test_target_word[TT_S_BIT]) |-> (attribution != ATTR_NONSECURE))
    else $error("response word secure flag disagrees with attribution");

  // no valid match means region number zero
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !matched_valid) |-> (matched_region == '0))
    else $error("region number set without a valid match");

endmodule

`default_nettype wire
